// File: rtl/mnps_pkg.sv
// Shared types and constants for the monophonic note priority stack.
package mnps_pkg;

   // Note and cell index widths (depth is at most 128 entries)
   localparam int unsigned NOTE_W     = 7;
   localparam int unsigned CELL_IDX_W = 7;

   // Request action codes
   localparam logic [1:0] ACT_NOTE_OFF = 2'd0;
   localparam logic [1:0] ACT_NOTE_ON  = 2'd1;
   localparam logic [1:0] ACT_CLEAR    = 2'd2;

   // Highest legal note number
   localparam logic [7:0] NOTE_MAX = 8'd127;

   // Priority modes
   localparam logic MODE_LAST = 1'b0;
   localparam logic MODE_LOW  = 1'b1;

   // Register indexes
   localparam logic REG_PRIORITY_MODE = 1'b0;

   // Control broadcast to every cell of the chain
   typedef struct packed {
      logic                  shift;
      logic                  wr_en;
      logic [CELL_IDX_W-1:0] wr_idx;
      logic [NOTE_W-1:0]     wr_data;
   } cell_ctl_type;

endpackage

// File: rtl/mnps_cell.sv
// One entry of the held-note chain: loads from its upper neighbor or a direct write.
module mnps_cell
   import mnps_pkg::*;
#(
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic              clock,
   input  cell_ctl_type      ctl,
   input  logic [NOTE_W-1:0] from_next,
   output logic [NOTE_W-1:0] note
);

   logic [NOTE_W-1:0] note_ff;
   logic [NOTE_W-1:0] note_in;
   logic              hit;

   assign hit = ctl.wr_en && (ctl.wr_idx == CELL_IDX_W'(CELL_INDEX));

   // Direct write wins over the shift toward the head
   always_comb begin
      if (hit) begin
         note_in = ctl.wr_data;
      end else if (ctl.shift) begin
         note_in = from_next;
      end else begin
         note_in = note_ff;
      end
   end

   always_ff @(posedge clock) begin
      note_ff <= note_in;
   end

   assign note = note_ff;

endmodule

// File: rtl/mono_note_priority_stack.sv
// Monophonic note priority stack: held notes live in a chain of cells, oldest at cell 0.
// Each request passes through an accept cycle, then (when notes are held) one
// rotation step per held note through the cell chain (the head entry is compared, folded
// into the minimum trackers and written back at the tail unless it is the removed note),
// and an update cycle that appends a note-on and loads the result register. The request
// side is ready again as soon as the update cycle is done; a pending result is held in the
// output register, and the update cycle of the next request waits until that result has
// been transferred. The list needs no clearing after reset.
module mono_note_priority_stack
   import mnps_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic [7:0]        req_note,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [NOTE_W-1:0] rsp_previous_note,
   output logic              rsp_previous_valid,
   output logic [NOTE_W-1:0] rsp_active_note,
   output logic              rsp_active_valid,
   output logic              rsp_active_changed,
   output logic              rsp_legato,
   output logic              rsp_already_held,
   // configuration port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_POST = 2'd2;

   localparam logic [NOTE_W-1:0] MIN_INIT = NOTE_W'(NOTE_MAX);

   // ---------------------------------------------------------------- config
   logic priority_mode_ff;
   logic csr_wr;
   logic csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         priority_mode_ff <= MODE_LAST;
      end else if (csr_wr && (csr_index == REG_PRIORITY_MODE)) begin
         priority_mode_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_index == REG_PRIORITY_MODE) ? {31'd0, priority_mode_ff} : 32'd0;

   // ---------------------------------------------------------------- state
   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  n_ff;
   logic [CNT_W-1:0]  step_ff;
   logic [1:0]        action_ff;
   logic [7:0]        note_ff;
   logic              found_ff;
   logic [NOTE_W-1:0] min_all_ff, min_kept_ff, min_excl_ff;
   logic [NOTE_W-1:0] last_all_ff, last_kept_ff;

   logic [NOTE_W-1:0] rsp_prev_note_ff, rsp_act_note_ff;
   logic              rsp_prev_valid_ff, rsp_act_valid_ff, rsp_changed_ff;
   logic              rsp_legato_ff, rsp_already_ff, rsp_valid_ff;

   // ---------------------------------------------------------------- cell chain
   cell_ctl_type      ctl;
   logic [NOTE_W-1:0] cell_note [STACK_DEPTH];

   for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      logic [NOTE_W-1:0] from_next;
      if (gi == STACK_DEPTH - 1) begin : g_tail
         assign from_next = '0;
      end else begin : g_body
         assign from_next = cell_note[gi+1];
      end
      mnps_cell #(
         .CELL_INDEX (gi)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .from_next (from_next),
         .note      (cell_note[gi])
      );
   end

   // ---------------------------------------------------------------- decode
   logic              accept;
   logic              op_valid, on_valid, off_valid, is_clear;
   logic [NOTE_W-1:0] head;
   logic              scan_match;
   logic              scan_last;
   logic              post_go;
   logic [CNT_W-1:0]  kept;
   logic              kept_full;
   logic [CNT_W-1:0]  tail_pos;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign op_valid   = ((action_ff == ACT_NOTE_ON) || (action_ff == ACT_NOTE_OFF))
                       && (note_ff <= NOTE_MAX);
   assign on_valid   = op_valid && (action_ff == ACT_NOTE_ON);
   assign off_valid  = op_valid && (action_ff == ACT_NOTE_OFF);
   assign is_clear   = (action_ff == ACT_CLEAR);
   assign head       = cell_note[0];
   assign scan_match = op_valid && (head == note_ff[NOTE_W-1:0]);
   assign scan_last  = (step_ff == n_ff - CNT_W'(1));
   assign post_go    = !rsp_valid_ff || rsp_ready;
   assign kept       = n_ff - CNT_W'(found_ff);
   assign kept_full  = (kept == CNT_W'(STACK_DEPTH));
   assign tail_pos   = n_ff - CNT_W'(1) - CNT_W'(found_ff);

   // ---------------------------------------------------------------- chain control
   always_comb begin
      ctl = '0;
      if (state_ff == ST_SCAN) begin
         // rotate: head leaves, rest moves down, head goes back at the tail unless it matches
         ctl.shift   = 1'b1;
         ctl.wr_en   = !scan_match;
         ctl.wr_idx  = CELL_IDX_W'(tail_pos);
         ctl.wr_data = head;
      end else if ((state_ff == ST_POST) && post_go && on_valid) begin
         // append; a full list drops the oldest entry in the same cycle
         ctl.wr_en   = 1'b1;
         ctl.wr_data = note_ff[NOTE_W-1:0];
         if (kept_full) begin
            ctl.shift  = 1'b1;
            ctl.wr_idx = CELL_IDX_W'(STACK_DEPTH - 1);
         end else begin
            ctl.wr_idx = CELL_IDX_W'(kept);
         end
      end
   end

   // ---------------------------------------------------------------- result
   logic              prev_valid, new_valid;
   logic [NOTE_W-1:0] prev_note, new_note;
   logic [NOTE_W-1:0] on_min_base, on_min;

   assign on_min_base = kept_full ? min_excl_ff : min_kept_ff;
   assign on_min      = (note_ff[NOTE_W-1:0] < on_min_base) ? note_ff[NOTE_W-1:0]
                                                             : on_min_base;

   always_comb begin
      prev_valid = (n_ff != '0);
      prev_note  = '0;
      if (prev_valid) begin
         prev_note = (priority_mode_ff == MODE_LOW) ? min_all_ff : last_all_ff;
      end

      new_valid = prev_valid;
      new_note  = prev_note;
      cnt_in    = n_ff;
      if (is_clear) begin
         new_valid = 1'b0;
         new_note  = '0;
         cnt_in    = '0;
      end else if (on_valid) begin
         new_valid = 1'b1;
         new_note  = (priority_mode_ff == MODE_LOW) ? on_min : note_ff[NOTE_W-1:0];
         cnt_in    = kept_full ? kept : kept + CNT_W'(1);
      end else if (off_valid) begin
         new_valid = (kept != '0);
         new_note  = '0;
         if (new_valid) begin
            new_note = (priority_mode_ff == MODE_LOW) ? min_kept_ff : last_kept_ff;
         end
         cnt_in    = kept;
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (cnt_ff == '0) ? ST_POST : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (post_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_POST) && post_go) begin
            cnt_ff       <= cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Per-request working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff    <= req_action;
         note_ff      <= req_note;
         n_ff         <= cnt_ff;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         min_all_ff   <= MIN_INIT;
         min_kept_ff  <= MIN_INIT;
         min_excl_ff  <= MIN_INIT;
         last_all_ff  <= '0;
         last_kept_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         step_ff     <= step_ff + CNT_W'(1);
         last_all_ff <= head;
         if (head < min_all_ff) begin
            min_all_ff <= head;
         end
         if (scan_match) begin
            found_ff <= 1'b1;
         end else begin
            last_kept_ff <= head;
            if (head < min_kept_ff) begin
               min_kept_ff <= head;
            end
            if ((step_ff != '0) && (head < min_excl_ff)) begin
               min_excl_ff <= head;
            end
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if ((state_ff == ST_POST) && post_go) begin
         rsp_prev_note_ff  <= prev_note;
         rsp_prev_valid_ff <= prev_valid;
         rsp_act_note_ff   <= new_note;
         rsp_act_valid_ff  <= new_valid;
         rsp_changed_ff    <= (prev_valid != new_valid) || (prev_valid && (prev_note != new_note));
         rsp_legato_ff     <= on_valid && prev_valid;
         rsp_already_ff    <= on_valid && found_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_previous_note  = rsp_prev_note_ff;
   assign rsp_previous_valid = rsp_prev_valid_ff;
   assign rsp_active_note    = rsp_act_note_ff;
   assign rsp_active_valid   = rsp_act_valid_ff;
   assign rsp_active_changed = rsp_changed_ff;
   assign rsp_legato         = rsp_legato_ff;
   assign rsp_already_held   = rsp_already_ff;

   // ---------------------------------------------------------------- checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("held count exceeds stack depth");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_match) |-> !found_ff)
      else $error("note found twice in held list");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (step_ff < n_ff))
      else $error("rotation ran past held count");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_act_valid_ff == (cnt_ff != '0)))
      else $error("pending result disagrees with held count");

endmodule
